// ----- hdl/mrpu_pkg.sv -----
`default_nettype none

package mrpu_pkg;

   // field widths
   localparam int IndexW   = 10;
   localparam int ValueW   = 32;
   localparam int GradW    = 48;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam int ReqDataW = 176;
   localparam int RspDataW = 80;

   localparam int MaxParamsDefault = 1024;

   // largest Q8.40 magnitude held in a moment
   localparam logic [46:0] Lim47 = '1;

   // pipeline map
   localparam int StWb       = 8;
   localparam int StSq0      = 9;
   localparam int SqrtBits   = 3;
   localparam int SqrtStages = 24 / SqrtBits;
   localparam int StDen      = StSq0 + SqrtStages;
   localparam int StDv0      = StDen + 1;
   localparam int DivBits    = 4;
   localparam int DivStages  = 40 / DivBits;
   localparam int StLast     = StDv0 + DivStages;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_GRAD_SCALE      = 3'd0,
      CSR_MOMENTUM_WEIGHT = 3'd1,
      CSR_VELOCITY_WEIGHT = 3'd2,
      CSR_STEP_RATE       = 3'd3,
      CSR_STABILIZER      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] grad_scale;
      logic [15:0]        momentum_weight;
      logic [15:0]        velocity_weight;
      logic [31:0]        step_rate;
      logic [15:0]        stabilizer;
   } cfg_type;

   typedef struct packed {
      logic signed [47:0] m_mg;
      logic signed [47:0] m_eg;
      logic signed [47:0] v_mg;
      logic signed [47:0] v_eg;
   } moment_row_type;

   // index folded into the table, by repeated compare and subtract
   function automatic int slot_of(int idx, int modulus);
      int rem;
      rem = idx;
      for (int k = IndexW - 1; k >= 0; k--) begin
         if (rem >= (modulus << k)) begin
            rem = rem - (modulus << k);
         end
      end
      return rem;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/mrpu_moment_store.sv -----
`default_nettype none

module mrpu_moment_store import mrpu_pkg::*; #(
   parameter int MAX_PARAMS = MaxParamsDefault,
   localparam int SlotW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [SlotW-1:0] rd_slot,
   output      moment_row_type   rd_row,
   input  wire logic             wr_en,
   input  wire logic [SlotW-1:0] wr_slot,
   input  wire moment_row_type   wr_row,
   output      logic             busy
);

   moment_row_type   mem [MAX_PARAMS];
   moment_row_type   rd_row_ff;
   logic [SlotW-1:0] clr_cnt_ff, clr_cnt_in;
   logic             busy_ff, busy_in;

   // clearing sweep after reset, one row a cycle
   always_comb begin
      busy_in    = busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == SlotW'(MAX_PARAMS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_slot] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= mem[rd_slot];
      end
   end

   assign rd_row = rd_row_ff;
   assign busy   = busy_ff;

endmodule

`default_nettype wire

// ----- hdl/mrpu_sqrt_stage.sv -----
`default_nettype none

module mrpu_sqrt_stage import mrpu_pkg::*; #(
   parameter int TOP_STEP = 23
) (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [47:0] x_in,
   input  wire logic [47:0] r_in,
   output      logic [47:0] x_out,
   output      logic [47:0] r_out
);

   logic [47:0] x_nx, r_nx, bitv;
   logic [47:0] x_ff, r_ff;

   // SqrtBits digit steps of the bitwise root
   always_comb begin
      x_nx = x_in;
      r_nx = r_in;
      bitv = '0;
      for (int j = 0; j < SqrtBits; j++) begin
         bitv = 48'd1 << (2 * (TOP_STEP - j));
         if (x_nx >= r_nx + bitv) begin
            x_nx = x_nx - (r_nx + bitv);
            r_nx = (r_nx >> 1) + bitv;
         end else begin
            r_nx = r_nx >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_nx;
         r_ff <= r_nx;
      end
   end

   assign x_out = x_ff;
   assign r_out = r_ff;

endmodule

`default_nettype wire

// ----- hdl/mrpu_div_stage.sv -----
`default_nettype none

module mrpu_div_stage import mrpu_pkg::*; #(
   parameter int TOP_BIT = 39
) (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [24:0] den_in,
   input  wire logic [39:0] num_in,
   input  wire logic [25:0] rem_in,
   input  wire logic [39:0] quo_in,
   output      logic [24:0] den_out,
   output      logic [39:0] num_out,
   output      logic [25:0] rem_out,
   output      logic [39:0] quo_out
);

   logic [25:0] rem_nx, rem_ff;
   logic [39:0] quo_nx, quo_ff, num_ff;
   logic [24:0] den_ff;

   // restoring division, DivBits quotient bits
   always_comb begin
      rem_nx = rem_in;
      quo_nx = quo_in;
      for (int j = 0; j < DivBits; j++) begin
         rem_nx = {rem_nx[24:0], num_in[TOP_BIT - j]};
         if (rem_nx >= {1'b0, den_in}) begin
            rem_nx = rem_nx - {1'b0, den_in};
            quo_nx[TOP_BIT - j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= den_in;
         num_ff <= num_in;
         rem_ff <= rem_nx;
         quo_ff <= quo_nx;
      end
   end

   assign den_out = den_ff;
   assign num_out = num_ff;
   assign rem_out = rem_ff;
   assign quo_out = quo_ff;

endmodule

`default_nettype wire

// ----- hdl/mrpu_lane.sv -----
`default_nettype none

module mrpu_lane import mrpu_pkg::*; (
   input  wire logic               clock,
   input  wire logic [StLast:1]    en,
   input  wire cfg_type            cfg,
   input  wire logic signed [31:0] value_in,
   input  wire logic signed [47:0] grad_in,
   input  wire logic signed [47:0] m_old,
   input  wire logic signed [47:0] v_old,
   output      logic signed [47:0] m_wb,
   output      logic signed [47:0] v_wb,
   output      logic signed [31:0] result
);

   logic signed [31:0] val_ff [1:StLast-1];
   logic [47:0]        gmag1_ff;
   logic               gneg1_ff;
   logic signed [47:0] m_ff [2:5];
   logic signed [47:0] v_ff [2:7];
   logic [55:0]        pl2_ff, ph2_ff;
   logic               neg2_ff;
   logic [46:0]        gm3_ff;
   logic signed [47:0] g3_ff;
   logic [45:0]        aa4_ff;
   logic [46:0]        ab4_ff;
   logic [47:0]        bb4_ff;
   logic signed [48:0] dm4_ff;
   logic [46:0]        sq5_ff;
   logic signed [65:0] mp5_ff;
   logic signed [47:0] mn_ff [6:8];
   logic signed [48:0] dv6_ff;
   logic signed [65:0] vp7_ff;
   logic [47:0]        mabs_ff [7:8];
   logic               mneg_ff [7:StLast-1];
   logic signed [47:0] vn8_ff;
   logic [55:0]        pl9_ff, ph9_ff;
   logic [59:0]        nsh_ff [10:StDen-1];
   logic [24:0]        den17_ff;
   logic [25:0]        rem17_ff;
   logic [39:0]        num17_ff;
   logic               zero_ff [StDen:StLast-1];
   logic               ovf_ff [StDen:StLast-1];
   logic signed [31:0] res_ff;

   logic [47:0]        gmag_in;
   logic [31:0]        smag;
   logic [56:0]        gsum;
   logic [46:0]        gm_c;
   logic [47:0]        g_c;
   logic [93:0]        sqfull;
   logic [46:0]        sq_c;
   logic [16:0]        cm, cv;
   logic signed [65:0] msum, vsum;
   logic [79:0]        nfull;
   logic [24:0]        den_c;
   logic [40:0]        u;
   logic signed [41:0] rs;
   logic signed [31:0] res_c;

   logic [47:0]        sq_x [0:SqrtStages];
   logic [47:0]        sq_r [0:SqrtStages];
   logic [24:0]        d_den [0:DivStages];
   logic [39:0]        d_num [0:DivStages];
   logic [25:0]        d_rem [0:DivStages];
   logic [39:0]        d_quo [0:DivStages];

   always_comb begin
      gmag_in = grad_in[47] ? (~grad_in + 48'd1) : grad_in;
      smag    = cfg.grad_scale[31] ? (~cfg.grad_scale + 32'd1) : cfg.grad_scale;
      gsum    = 57'(ph2_ff) + 57'(pl2_ff[55:24]);
      gm_c    = (gsum > 57'(Lim47)) ? Lim47 : gsum[46:0];
      g_c     = neg2_ff ? (~{1'b0, gm_c} + 48'd1) : {1'b0, gm_c};
      sqfull  = (94'(aa4_ff) << 48) + (94'(ab4_ff) << 25) + 94'(bb4_ff);
      sq_c    = (sqfull[93:40] > 54'(Lim47)) ? Lim47 : sqfull[86:40];
      cm      = 17'd65536 - 17'(cfg.momentum_weight);
      cv      = 17'd65536 - 17'(cfg.velocity_weight);
      msum    = 66'(m_ff[5]) + (mp5_ff >>> 16);
      vsum    = 66'(v_ff[7]) + (vp7_ff >>> 16);
      nfull   = (80'(ph9_ff) << 24) + 80'(pl9_ff);
      den_c   = 25'(cfg.stabilizer) + 25'(sq_r[SqrtStages][23:0]);
      if (zero_ff[StLast-1]) begin
         u = '0;
      end else if (ovf_ff[StLast-1]) begin
         u = 41'h100_0000_0000;
      end else begin
         u = {1'b0, d_quo[DivStages]};
      end
      if (mneg_ff[StLast-1]) begin
         rs = 42'(val_ff[StLast-1]) + $signed({1'b0, u});
      end else begin
         rs = 42'(val_ff[StLast-1]) - $signed({1'b0, u});
      end
      if (rs > 42'sd2147483647) begin
         res_c = 32'sh7FFF_FFFF;
      end else if (rs < -42'sd2147483648) begin
         res_c = 32'sh8000_0000;
      end else begin
         res_c = rs[31:0];
      end
   end

   // stages one to eight: gradient scale, square, moment blends; then step product, denominator, result
   always_ff @(posedge clock) begin
      if (en[1]) begin
         val_ff[1] <= value_in;
         gmag1_ff  <= gmag_in;
         gneg1_ff  <= grad_in[47];
      end
      if (en[2]) begin
         pl2_ff  <= 56'(gmag1_ff[23:0]) * 56'(smag);
         ph2_ff  <= 56'(gmag1_ff[47:24]) * 56'(smag);
         neg2_ff <= gneg1_ff ^ cfg.grad_scale[31];
         m_ff[2] <= m_old;
         v_ff[2] <= v_old;
      end
      if (en[3]) begin
         gm3_ff  <= gm_c;
         g3_ff   <= g_c;
         m_ff[3] <= m_ff[2];
         v_ff[3] <= v_ff[2];
      end
      if (en[4]) begin
         aa4_ff  <= 46'(gm3_ff[46:24]) * 46'(gm3_ff[46:24]);
         ab4_ff  <= 47'(gm3_ff[46:24]) * 47'(gm3_ff[23:0]);
         bb4_ff  <= 48'(gm3_ff[23:0]) * 48'(gm3_ff[23:0]);
         dm4_ff  <= 49'(g3_ff) - 49'(m_ff[3]);
         m_ff[4] <= m_ff[3];
         v_ff[4] <= v_ff[3];
      end
      if (en[5]) begin
         sq5_ff  <= sq_c;
         mp5_ff  <= 66'(dm4_ff) * 66'($signed({1'b0, cm}));
         m_ff[5] <= m_ff[4];
         v_ff[5] <= v_ff[4];
      end
      if (en[6]) begin
         mn_ff[6] <= msum[47:0];
         dv6_ff   <= $signed({2'b00, sq5_ff}) - 49'(v_ff[5]);
         v_ff[6]  <= v_ff[5];
      end
      if (en[7]) begin
         vp7_ff     <= 66'(dv6_ff) * 66'($signed({1'b0, cv}));
         mn_ff[7]   <= mn_ff[6];
         mabs_ff[7] <= mn_ff[6][47] ? (~mn_ff[6] + 48'd1) : mn_ff[6];
         mneg_ff[7] <= mn_ff[6][47];
         v_ff[7]    <= v_ff[6];
      end
      if (en[StWb]) begin
         vn8_ff        <= vsum[65] ? 48'sd0 : vsum[47:0];
         mn_ff[StWb]   <= mn_ff[7];
         mabs_ff[StWb] <= mabs_ff[7];
      end
      if (en[StSq0]) begin
         pl9_ff <= 56'(cfg.step_rate) * 56'(mabs_ff[StWb][23:0]);
         ph9_ff <= 56'(cfg.step_rate) * 56'(mabs_ff[StWb][47:24]);
      end
      if (en[StSq0+1]) begin
         nsh_ff[StSq0+1] <= nfull[79:20];
      end
      if (en[StDen]) begin
         den17_ff       <= den_c;
         rem17_ff       <= 26'(nsh_ff[StDen-1][59:40]);
         num17_ff       <= nsh_ff[StDen-1][39:0];
         zero_ff[StDen] <= (den_c == 25'd0);
         ovf_ff[StDen]  <= ({5'd0, nsh_ff[StDen-1][59:40]} >= den_c);
      end
      if (en[StLast]) begin
         res_ff <= res_c;
      end
   end

   // side payload riding along
   for (genvar k = 2; k < StLast; k++) begin : g_val
      always_ff @(posedge clock) begin
         if (en[k]) begin
            val_ff[k] <= val_ff[k-1];
         end
      end
   end

   for (genvar k = StWb; k < StLast; k++) begin : g_mneg
      always_ff @(posedge clock) begin
         if (en[k]) begin
            mneg_ff[k] <= mneg_ff[k-1];
         end
      end
   end

   for (genvar k = StSq0 + 2; k < StDen; k++) begin : g_nsh
      always_ff @(posedge clock) begin
         if (en[k]) begin
            nsh_ff[k] <= nsh_ff[k-1];
         end
      end
   end

   for (genvar k = StDen + 1; k < StLast; k++) begin : g_flag
      always_ff @(posedge clock) begin
         if (en[k]) begin
            zero_ff[k] <= zero_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
         end
      end
   end

   // root of the second moment
   assign sq_x[0] = vn8_ff;
   assign sq_r[0] = '0;

   for (genvar j = 0; j < SqrtStages; j++) begin : g_sqrt
      mrpu_sqrt_stage #(
         .TOP_STEP(23 - SqrtBits * j)
      ) u_sqrt (
         .clock (clock),
         .en    (en[StSq0 + j]),
         .x_in  (sq_x[j]),
         .r_in  (sq_r[j]),
         .x_out (sq_x[j+1]),
         .r_out (sq_r[j+1])
      );
   end

   // step size over the denominator
   assign d_den[0] = den17_ff;
   assign d_num[0] = num17_ff;
   assign d_rem[0] = rem17_ff;
   assign d_quo[0] = '0;

   for (genvar j = 0; j < DivStages; j++) begin : g_div
      mrpu_div_stage #(
         .TOP_BIT(39 - DivBits * j)
      ) u_div (
         .clock   (clock),
         .en      (en[StDv0 + j]),
         .den_in  (d_den[j]),
         .num_in  (d_num[j]),
         .rem_in  (d_rem[j]),
         .quo_in  (d_quo[j]),
         .den_out (d_den[j+1]),
         .num_out (d_num[j+1]),
         .rem_out (d_rem[j+1]),
         .quo_out (d_quo[j+1])
      );
   end

   assign m_wb   = mn_ff[StWb];
   assign v_wb   = vn8_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

// ----- hdl/momentum_rms_param_update.sv -----
// momentum_rms_param_update: per-parameter momentum / rms-normalized update
//
// req channel: one word per parameter, index plus midgame and endgame values
// and their accumulated gradients. rsp channel: one word per request, in
// order, holding the index and both updated values, saturated to 32 bits.
// csr channel: register writes, always ready; write only while idle.
//
// the stages are eight of gradient scaling and moment blending, eight root
// stages at three bits each, one denominator stage, ten divide stages at four
// quotient bits each, and the output stage. a new word can enter every cycle
// unless a stall, a table-row hazard or the table clear holds it back.
// a word whose index maps to the same table row as a word in the first
// eight stages waits until that word has written its moments back, so
// repeated indices within eight words of each other stall the input.
//
// reset clears the registers to their defaults and starts a sweep that
// zeroes the moment table, during which req_tready is low.
// when rsp_tready is low the stages fill up from the output backwards,
// bubbles collapse, and the stall reaches req_tready only once the pipeline is full.
`default_nettype none

module momentum_rms_param_update import mrpu_pkg::*; #(
   parameter int MAX_PARAMS = MaxParamsDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   // param_index, value_mg, value_eg, grad_sum_mg, grad_sum_eg, zero fill
   input  wire logic [ReqDataW-1:0] req_tdata,
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   // out_index, new_mg, new_eg, zero fill
   output      logic [RspDataW-1:0] rsp_tdata,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [CsrAddrW-1:0] csr_index,
   input  wire logic [CsrDataW-1:0] csr_data
);

   localparam int SlotW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // pipeline control, one valid bit per stage
   logic [StLast:1]   valid_ff, valid_in;
   logic [StLast+1:1] en;
   logic              accept;
   logic              hazard;
   logic              clear_busy;

   // index and table row riding with the word
   logic [IndexW-1:0] idx_ff [1:StLast];
   logic [SlotW-1:0]  slot_ff [1:StWb];
   logic [SlotW-1:0]  slot_in;

   moment_row_type    rd_row, wr_row;
   logic signed [31:0] new_mg, new_eg;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_GRAD_SCALE:      cfg_in.grad_scale      = csr_data;
            CSR_MOMENTUM_WEIGHT: cfg_in.momentum_weight = csr_data[15:0];
            CSR_VELOCITY_WEIGHT: cfg_in.velocity_weight = csr_data[15:0];
            CSR_STEP_RATE:       cfg_in.step_rate       = csr_data;
            CSR_STABILIZER:      cfg_in.stabilizer      = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grad_scale      <= 32'sd0;
         cfg_ff.momentum_weight <= 16'd58982;
         cfg_ff.velocity_weight <= 16'd65470;
         cfg_ff.step_rate       <= 32'd65536;
         cfg_ff.stabilizer      <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // table row of the incoming index
   assign slot_in = SlotW'(slot_of(int'(req_tdata[9:0]), MAX_PARAMS));

   // hold back a word whose row is still being updated
   always_comb begin
      hazard = 1'b0;
      for (int k = 1; k <= StWb; k++) begin
         if (valid_ff[k] && (slot_ff[k] == slot_in)) begin
            hazard = 1'b1;
         end
      end
   end

   // stall chain: a stage loads when empty or when the next one moves
   always_comb begin
      en[StLast+1] = rsp_tready;
      for (int k = StLast; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[1] && !hazard && !clear_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (en[1]) begin
         valid_in[1] = accept;
      end
      for (int k = 2; k <= StLast; k++) begin
         if (en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         idx_ff[1]  <= req_tdata[9:0];
         slot_ff[1] <= slot_in;
      end
   end

   for (genvar k = 2; k <= StLast; k++) begin : g_idx
      always_ff @(posedge clock) begin
         if (en[k]) begin
            idx_ff[k] <= idx_ff[k-1];
         end
      end
   end

   for (genvar k = 2; k <= StWb; k++) begin : g_slot
      always_ff @(posedge clock) begin
         if (en[k]) begin
            slot_ff[k] <= slot_ff[k-1];
         end
      end
   end

   // moment table, read on entry, written back from the blend stage
   mrpu_moment_store #(
      .MAX_PARAMS(MAX_PARAMS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (en[1]),
      .rd_slot (slot_in),
      .rd_row  (rd_row),
      .wr_en   (valid_ff[StWb]),
      .wr_slot (slot_ff[StWb]),
      .wr_row  (wr_row),
      .busy    (clear_busy)
   );

   // midgame and endgame lanes
   mrpu_lane u_lane_mg (
      .clock    (clock),
      .en       (en[StLast:1]),
      .cfg      (cfg_ff),
      .value_in ($signed(req_tdata[41:10])),
      .grad_in  ($signed(req_tdata[121:74])),
      .m_old    (rd_row.m_mg),
      .v_old    (rd_row.v_mg),
      .m_wb     (wr_row.m_mg),
      .v_wb     (wr_row.v_mg),
      .result   (new_mg)
   );

   mrpu_lane u_lane_eg (
      .clock    (clock),
      .en       (en[StLast:1]),
      .cfg      (cfg_ff),
      .value_in ($signed(req_tdata[73:42])),
      .grad_in  ($signed(req_tdata[169:122])),
      .m_old    (rd_row.m_eg),
      .v_old    (rd_row.v_eg),
      .m_wb     (wr_row.m_eg),
      .v_wb     (wr_row.v_eg),
      .result   (new_eg)
   );

   // the last stage is the output register
   assign rsp_tvalid = valid_ff[StLast];
   assign rsp_tdata  = {6'd0, new_eg, new_mg, idx_ff[StLast]};

   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[1])
      else $error("accepted word missing from first stage");

   a_row_exclusive : assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && valid_ff[StWb] |-> slot_ff[1] != slot_ff[StWb])
      else $error("two words on one table row inside the update window");

   a_clear_quiet : assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_tready && !valid_ff[StWb])
      else $error("word in flight during table clear");

endmodule

`default_nettype wire

// ----- tb/tb_momentum_rms_param_update.sv -----
`timescale 1ns / 1ps

module tb_momentum_rms_param_update import mrpu_pkg::*; ();

   localparam int NumParams = MaxParamsDefault;
   localparam logic [63:0] Lim47Mag = 64'h7FFF_FFFF_FFFF;
   localparam logic [63:0] StepCap  = 64'd1 << 40;

   // updated parameter pair as it leaves the block, lowest field last
   typedef struct packed {
      logic signed [31:0] eg;
      logic signed [31:0] mg;
      logic [9:0]         index;
   } update_word_type;

   // predicts the update of each parameter and holds the pending results
   class update_scoreboard_type;
      logic signed [63:0] momentum [2*NumParams];
      logic signed [63:0] velocity [2*NumParams];
      logic signed [31:0] scale;
      logic [15:0]        mweight;
      logic [15:0]        vweight;
      logic [31:0]        rate;
      logic [15:0]        eps;
      update_word_type    pending [$];
      int                 mismatches;

      function void clear();
         for (int i = 0; i < 2*NumParams; i++) begin
            momentum[i] = 0;
            velocity[i] = 0;
         end
         scale = 0;
         mweight = 16'd58982;
         vweight = 16'd65470;
         rate = 32'd65536;
         eps = 16'd1;
         mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] data);
         case (idx)
            CSR_GRAD_SCALE:      scale = data;
            CSR_MOMENTUM_WEIGHT: mweight = data[15:0];
            CSR_VELOCITY_WEIGHT: vweight = data[15:0];
            CSR_STEP_RATE:       rate = data;
            CSR_STABILIZER:      eps = data[15:0];
            default: ;
         endcase
      endfunction

      // old + floor((sample - old) * (65536 - w) / 65536)
      function logic signed [63:0] blend(logic signed [63:0] old_v,
                                         logic signed [63:0] sample,
                                         logic [15:0] w);
         logic signed [95:0] prod;
         prod = 96'(sample - old_v) * $signed({1'b0, 17'd65536 - 17'(w)});
         return old_v + 64'(prod >>> 16);
      endfunction

      function logic [63:0] root(logic [63:0] v);
         logic [63:0] r;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            logic [63:0] t;
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      function logic signed [31:0] phase(int slot, logic signed [31:0] value,
                                         logic signed [47:0] grad);
         logic [127:0]       p;
         logic [63:0]        gm, sq, den, u;
         logic signed [63:0] g, m, v, res;
         p = 128'(grad < 0 ? -64'(grad) : 64'(grad))
             * 128'(scale < 0 ? -64'(scale) : 64'(scale));
         gm = (p >> 24) > Lim47Mag ? Lim47Mag : 64'(p >> 24);
         g = ((grad < 0) != (scale < 0)) ? -$signed(gm) : $signed(gm);
         m = blend(momentum[slot], g, mweight);
         momentum[slot] = m;
         p = 128'(gm) * 128'(gm);
         sq = (p >> 40) > Lim47Mag ? Lim47Mag : 64'(p >> 40);
         v = blend(velocity[slot], $signed(sq), vweight);
         if (v < 0) v = 0;
         velocity[slot] = v;
         den = 64'(eps) + root(v);
         if (den == 0) u = 0;
         else begin
            p = 128'(rate) * 128'(m < 0 ? -m : m);
            p = p / (128'(den) << 20);
            u = p > 128'(StepCap) ? StepCap : 64'(p);
         end
         res = m < 0 ? 64'(value) + $signed(u) : 64'(value) - $signed(u);
         if (res > 64'sd2147483647) res = 64'sd2147483647;
         if (res < -64'sd2147483648) res = -64'sd2147483648;
         return res[31:0];
      endfunction

      // note an accepted request word
      function void note_request(logic [ReqDataW-1:0] d);
         update_word_type w;
         int base;
         w.index = d[9:0];
         base = 2 * (int'(d[9:0]) % NumParams);
         w.mg = phase(base, d[41:10], d[121:74]);
         w.eg = phase(base + 1, d[73:42], d[169:122]);
         pending.insert(pending.size(), w);
      endfunction

      function void check_response(logic [RspDataW-1:0] d);
         update_word_type got, want;
         got = d[73:0];
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp word %h", got);
            return;
         end
         want = pending.pop_front();
         if (got.index !== want.index || got.mg !== want.mg || got.eg !== want.eg
             || d[79:74] !== 6'd0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp mismatch: idx %0d/%0d mg %h/%h eg %h/%h (exp/act)",
                        want.index, got.index, want.mg, got.mg, want.eg, got.eg);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;  // param_index, value_mg, value_eg, grad_sum_mg, grad_sum_eg
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;  // out_index, new_mg, new_eg
   logic                csr_valid;
   logic                csr_ready;
   logic [CsrAddrW-1:0] csr_index;
   logic [CsrDataW-1:0] csr_data;

   update_scoreboard_type sb;
   bit                    stim_done;

   momentum_rms_param_update dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit well beyond the slowest correct run
   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one request word; valid stays high across back-to-back words
   task automatic send_word(logic [9:0] idx, logic [31:0] vmg, logic [31:0] veg,
                            logic [47:0] gmg, logic [47:0] geg);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, geg, gmg, veg, vmg, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(req_tdata);
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   // wait until all results are back, then longer than the pipeline depth
   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic logic [47:0] rand_grad();
      case ($urandom_range(0, 3))
         0: return 48'({$urandom(), $urandom()});
         1: return 48'($signed($urandom_range(0, 65535)) - 32768) <<< 24;
         2: return 48'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return {{16{$urandom_range(0, 1) == 1}}, $urandom()};
      endcase
   endfunction

   // accepts and checks results, random backpressure
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_tready <= ($urandom_range(0, 3) != 0 || stim_done);
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         @(negedge clock);
         if (!stim_done && $urandom_range(0, 40) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end
      end
   end

   initial begin
      logic [31:0] scales [4];
      sb = new();
      sb.clear();
      stim_done = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_GRAD_SCALE;
      csr_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset scale of zero, then field extremes
      send_word(10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
      stop_sending();
      drain();
      write_csr(CSR_GRAD_SCALE, 32'h7FFF_FFFF);
      write_csr(CSR_STEP_RATE, 32'hFFFF_FFFF);
      send_word(10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
      send_word(10'd1023, 32'h8000_0000, 32'h7FFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
      send_word(10'd5, 32'h0, 32'h0, 48'h0, 48'h0);
      send_word(10'd5, 32'hFFFF_FFFF, 32'h1, 48'h1, 48'hFFFF_FFFF_FFFF);
      stop_sending();
      drain();
      // zero weights: averages take the new sample
      write_csr(CSR_MOMENTUM_WEIGHT, 32'd0);
      write_csr(CSR_VELOCITY_WEIGHT, 32'd0);
      write_csr(CSR_GRAD_SCALE, 32'h8000_0000);
      write_csr(CSR_STABILIZER, 32'd65535);
      for (int i = 0; i < 6; i++)
         send_word(10'(i * 200), $urandom(), $urandom(), rand_grad(), rand_grad());
      stop_sending();
      drain();
      // zero stabilizer with zero gradient: no update
      write_csr(CSR_STABILIZER, 32'd0);
      write_csr(CSR_GRAD_SCALE, 32'd0);
      send_word(10'd900, 32'h1234_5678, 32'h8765_4321, 48'h5, 48'h7);
      stop_sending();
      drain();
      write_csr(CSR_MOMENTUM_WEIGHT, 32'd65535);
      write_csr(CSR_VELOCITY_WEIGHT, 32'd65535);
      write_csr(CSR_STEP_RATE, 32'd0);
      send_word(10'd900, 32'h1234_5678, 32'h8765_4321, 48'h5, 48'h7);
      stop_sending();
      drain();

      // random phases across settings
      scales = '{32'h0000_4000, 32'hFFF0_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_GRAD_SCALE, ph < 4 ? scales[ph] : $urandom());
         write_csr(CSR_MOMENTUM_WEIGHT, ph == 7 ? 0 : $urandom_range(0, 65535));
         write_csr(CSR_VELOCITY_WEIGHT, ph == 6 ? 65535 : $urandom_range(0, 65535));
         write_csr(CSR_STEP_RATE, ph == 5 ? 32'hFFFF_FFFF : $urandom_range(0, 1 << 20));
         write_csr(CSR_STABILIZER, ph == 4 ? 0 : $urandom_range(1, 65535));
         for (int n = 0; n < 200; n++) begin
            // a small index pool makes repeats close together
            send_word($urandom_range(0, 3) == 0 ? 10'($urandom_range(0, 7)) : 10'($urandom()),
                      $urandom(), $urandom(), rand_grad(), rand_grad());
            if ($urandom_range(0, 30) == 0) begin
               stop_sending();
               @(negedge clock);
            end
         end
         stop_sending();
         drain();
      end

      stim_done = 1'b1;
      drain();
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
